@@ rtl/occu_pkg.sv @@
// Package for the online circle clusterer: sizes, scale constants, codes and
// the command/status structs shared by the controller and the datapath.
// No dependencies.
`default_nettype none
package occu_pkg;

   localparam int MAX_CLUSTERS = 16;
   localparam int IDX_W        = 4;
   localparam int CNT_W        = 5;
   localparam int COORD_W      = 16;
   localparam int PCT_W        = 15;
   localparam int CSR_IDX_W    = 4;
   localparam int NUM_W        = 34;
   localparam int DIVR_W       = 17;
   localparam int DCNT_W       = 6;
   localparam int LANES        = 3;

   localparam logic [DCNT_W-1:0] DIV_STEPS = 6'd34;
   localparam logic [14:0]       PCT_SCALE = 15'd25600;
   localparam logic [29:0]       PCT_SQ    = 30'd655360000;
   localparam logic [30:0]       FLAT_SC_RESET = 31'd819200;
   localparam logic [PCT_W-1:0]  PCT_RESET = 15'd2560;

   localparam logic [CSR_IDX_W-1:0] REG_FLAT_TOL    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_PERCENT_TOL = 4'd1;

   localparam logic [1:0] OUT_JOIN = 2'd0;
   localparam logic [1:0] OUT_NEW  = 2'd1;
   localparam logic [1:0] OUT_DROP = 2'd2;

   typedef struct packed {
      logic       load;
      logic       scan_next;
      logic       div_start;
      logic       commit;
      logic [1:0] outcome;
   } cmd_type;

   typedef struct packed {
      logic past_end;
      logic match;
      logic full;
      logic div_done;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/occu_datapath.sv @@
// Datapath: tolerance registers, cluster table, similarity pipeline,
// serial dividers for the average update and the result register.
// Depends on occu_pkg.
`default_nettype none
module occu_datapath (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              csr_valid,
   input  wire [occu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire [15:0]                       csr_data,
   input  wire                              in_first,
   input  wire [15:0]                       in_x,
   input  wire [15:0]                       in_y,
   input  wire [15:0]                       in_r,
   input  occu_pkg::cmd_type                cmd,
   output occu_pkg::stat_type               stat,
   output logic [3:0]                       res_index,
   output logic                             res_created,
   output logic                             res_dropped,
   output logic [15:0]                      res_x,
   output logic [15:0]                      res_y,
   output logic [15:0]                      res_r,
   output logic [15:0]                      res_members,
   output logic [4:0]                       res_total
);
   import occu_pkg::*;

   logic [30:0]        flat_sc_ff;
   logic [PCT_W-1:0]   pct_ff;
   logic signed [15:0] in_x_ff, in_y_ff;
   logic [15:0]        in_r_ff;

   logic signed [15:0] mean_x_ff [MAX_CLUSTERS];
   logic signed [15:0] mean_y_ff [MAX_CLUSTERS];
   logic [15:0]        mean_r_ff [MAX_CLUSTERS];
   logic [15:0]        members_ff [MAX_CLUSTERS];
   logic [CNT_W-1:0]   used_ff;
   logic [CNT_W-1:0]   idx_ff;

   logic signed [15:0] ent_x, ent_y;
   logic [15:0]        ent_r, ent_k;
   logic [15:0]        rs, rd;
   logic signed [16:0] dx, dy;
   logic signed [33:0] dxsq, dysq;

   logic [31:0]        t_ff;
   logic [30:0]        rdsc_ff;
   logic [31:0]        dxx_ff, dyy_ff;
   logic [32:0]        d2_ff;
   logic [63:0]        tt_ff, tt2_ff;
   logic               rad_ok_ff, rad2_ff;
   logic [63:0]        d2s_ff;

   logic [NUM_W-1:0]   dnum_ff [LANES];
   logic [DIVR_W-1:0]  drem_ff [LANES];
   logic               dneg_ff [LANES];
   logic [NUM_W-1:0]   dnum_in [LANES];
   logic [DIVR_W-1:0]  drem_in [LANES];
   logic [DIVR_W-1:0]  divisor_ff;
   logic [15:0]        dk_ff;
   logic [IDX_W-1:0]   hit_ff;
   logic [DCNT_W-1:0]  dcnt_ff;
   logic [15:0]        quo [LANES];

   logic signed [NUM_W-1:0] nx, ny;
   logic [NUM_W-1:0]        nr;
   logic [IDX_W-1:0]        slot;

   assign ent_x = mean_x_ff[idx_ff[IDX_W-1:0]];
   assign ent_y = mean_y_ff[idx_ff[IDX_W-1:0]];
   assign ent_r = mean_r_ff[idx_ff[IDX_W-1:0]];
   assign ent_k = members_ff[idx_ff[IDX_W-1:0]];
   assign slot  = used_ff[IDX_W-1:0];

   assign rs   = (ent_r < in_r_ff) ? ent_r : in_r_ff;
   assign rd   = (ent_r < in_r_ff) ? (in_r_ff - ent_r) : (ent_r - in_r_ff);
   assign dx   = {ent_x[15], ent_x} - {in_x_ff[15], in_x_ff};
   assign dy   = {ent_y[15], ent_y} - {in_y_ff[15], in_y_ff};
   assign dxsq = dx * dx;
   assign dysq = dy * dy;

   assign nx = $signed({{18{ent_x[15]}}, ent_x}) * $signed({18'd0, ent_k})
             + $signed({{18{in_x_ff[15]}}, in_x_ff});
   assign ny = $signed({{18{ent_y[15]}}, ent_y}) * $signed({18'd0, ent_k})
             + $signed({{18{in_y_ff[15]}}, in_y_ff});
   assign nr = {18'd0, ent_r} * {18'd0, ent_k} + {18'd0, in_r_ff};

   assign stat.past_end = idx_ff >= used_ff;
   assign stat.match    = rad2_ff && (d2s_ff < tt2_ff);
   assign stat.full     = used_ff == CNT_W'(MAX_CLUSTERS);
   assign stat.div_done = dcnt_ff == '0;

   // one restoring step per cycle, three lanes share the divisor
   always_comb begin
      logic [DIVR_W:0] trial;
      for (int l = 0; l < LANES; l++) begin
         trial = {drem_ff[l], dnum_ff[l][NUM_W-1]};
         if (trial >= {1'b0, divisor_ff}) begin
            drem_in[l] = DIVR_W'(trial - {1'b0, divisor_ff});
            dnum_in[l] = {dnum_ff[l][NUM_W-2:0], 1'b1};
         end else begin
            drem_in[l] = trial[DIVR_W-1:0];
            dnum_in[l] = {dnum_ff[l][NUM_W-2:0], 1'b0};
         end
         quo[l] = dneg_ff[l] ? (16'd0 - dnum_ff[l][15:0]) : dnum_ff[l][15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flat_sc_ff <= FLAT_SC_RESET;
         pct_ff     <= PCT_RESET;
      end else if (csr_valid) begin
         if (csr_index == REG_FLAT_TOL) begin
            flat_sc_ff <= 31'(csr_data) * 31'(PCT_SCALE);
         end
         if (csr_index == REG_PERCENT_TOL) begin
            pct_ff <= csr_data[PCT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      t_ff      <= {1'b0, flat_sc_ff} + 32'(rs) * 32'(pct_ff);
      rdsc_ff   <= 31'(rd) * 31'(PCT_SCALE);
      dxx_ff    <= dxsq[31:0];
      dyy_ff    <= dysq[31:0];
      d2_ff     <= {1'b0, dxx_ff} + {1'b0, dyy_ff};
      tt_ff     <= 64'(t_ff) * 64'(t_ff);
      rad_ok_ff <= {1'b0, rdsc_ff} < t_ff;
      d2s_ff    <= 64'(d2_ff[31:0]) * 64'(PCT_SQ)
                 + (d2_ff[32] ? {2'd0, PCT_SQ, 32'd0} : 64'd0);
      tt2_ff    <= tt_ff;
      rad2_ff   <= rad_ok_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         idx_ff  <= '0;
         dcnt_ff <= '0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
            if (in_first) begin
               used_ff <= '0;
            end
         end else if (cmd.scan_next) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmd.div_start) begin
            dcnt_ff <= DIV_STEPS;
         end else if (dcnt_ff != '0) begin
            dcnt_ff <= dcnt_ff - 1'b1;
         end
         if (cmd.commit && cmd.outcome == OUT_NEW) begin
            used_ff <= used_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         in_x_ff <= in_x;
         in_y_ff <= in_y;
         in_r_ff <= in_r;
      end
      if (cmd.div_start) begin
         hit_ff     <= idx_ff[IDX_W-1:0];
         dk_ff      <= ent_k;
         divisor_ff <= DIVR_W'(ent_k) + 1'b1;
         dneg_ff[0] <= nx[NUM_W-1];
         dneg_ff[1] <= ny[NUM_W-1];
         dneg_ff[2] <= 1'b0;
         dnum_ff[0] <= nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
         dnum_ff[1] <= ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
         dnum_ff[2] <= nr;
         for (int l = 0; l < LANES; l++) begin
            drem_ff[l] <= '0;
         end
      end else if (dcnt_ff != '0) begin
         for (int l = 0; l < LANES; l++) begin
            dnum_ff[l] <= dnum_in[l];
            drem_ff[l] <= drem_in[l];
         end
      end
      if (cmd.commit) begin
         case (cmd.outcome)
            OUT_JOIN: begin
               mean_x_ff[hit_ff]  <= quo[0];
               mean_y_ff[hit_ff]  <= quo[1];
               mean_r_ff[hit_ff]  <= quo[2];
               members_ff[hit_ff] <= (dk_ff == 16'hFFFF) ? dk_ff : dk_ff + 1'b1;
               res_index   <= hit_ff;
               res_created <= 1'b0;
               res_dropped <= 1'b0;
               res_x       <= quo[0];
               res_y       <= quo[1];
               res_r       <= quo[2];
               res_members <= (dk_ff == 16'hFFFF) ? dk_ff : dk_ff + 1'b1;
               res_total   <= used_ff;
            end
            OUT_NEW: begin
               mean_x_ff[slot]  <= in_x_ff;
               mean_y_ff[slot]  <= in_y_ff;
               mean_r_ff[slot]  <= in_r_ff;
               members_ff[slot] <= 16'd1;
               res_index   <= slot;
               res_created <= 1'b1;
               res_dropped <= 1'b0;
               res_x       <= in_x_ff;
               res_y       <= in_y_ff;
               res_r       <= in_r_ff;
               res_members <= 16'd1;
               res_total   <= used_ff + 1'b1;
            end
            default: begin
               res_index   <= '0;
               res_created <= 1'b0;
               res_dropped <= 1'b1;
               res_x       <= '0;
               res_y       <= '0;
               res_r       <= '0;
               res_members <= '0;
               res_total   <= used_ff;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

@@ rtl/occu_ctrl.sv @@
// Controller: request intake, cluster scan sequencing, divide wait and
// result handoff. Depends on occu_pkg.
`default_nettype none
module occu_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  wire                  rsp_tready,
   output occu_pkg::cmd_type    cmd,
   input  occu_pkg::stat_type   stat
);
   import occu_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_COMMIT = 2'd3;
   localparam logic [1:0] PHASE_LAST = 2'd3;

   logic [1:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] outcome_ff, outcome_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      outcome_in    = outcome_ff;
      req_tready    = 1'b0;
      cmd.load      = 1'b0;
      cmd.scan_next = 1'b0;
      cmd.div_start = 1'b0;
      cmd.commit    = 1'b0;
      cmd.outcome   = outcome_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               phase_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (phase_ff == '0 && stat.past_end) begin
               outcome_in = stat.full ? OUT_DROP : OUT_NEW;
               state_in   = ST_COMMIT;
            end else if (phase_ff == PHASE_LAST) begin
               phase_in = '0;
               if (stat.match) begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV;
               end else begin
                  cmd.scan_next = 1'b1;
               end
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (stat.div_done) begin
               outcome_in = OUT_JOIN;
               state_in   = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         outcome_ff   <= OUT_DROP;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         outcome_ff   <= outcome_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.scan_next, cmd.div_start, cmd.commit}))
      else $error("overlapping datapath commands");

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SCAN))
      else $error("accepted request did not start a scan");

   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid_ff)
      else $error("commit did not present a response");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_valid_ff || rsp_tready))
      else $error("commit over a pending response");

endmodule
`default_nettype wire

@@ rtl/online_circle_clusterer_unit.sv @@
// Top level of the online circle clusterer: stream ports, controller and
// datapath. Depends on occu_pkg, occu_ctrl, occu_datapath.
//
// Circles are taken one request at a time and each yields one response.
// From one accepted request to the next the block is busy with one pass
// through the similarity pipeline per cluster compared (table entries in
// creation order), plus, when it joins a cluster, the 34-step serial
// divider for the average update (its done check takes the place of the
// end-of-table check). The table holds at most 16 clusters. A new request
// is taken while a response still waits on the output; that request's
// result then waits until the output is free. The user must write the
// tolerance registers through the csr port only while idle; the block
// itself does not enforce this.
`default_nettype none
module online_circle_clusterer_unit (
   input  wire         clock,
   input  wire         reset,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [3:0]  csr_index,
   input  wire  [15:0] csr_data,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [47:0] req_tdata,   // center_x, center_y, radius
   input  wire         req_tuser,   // first_of_set
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [79:0] rsp_tdata,   // cluster_index, avg_center_x, avg_center_y,
                                    // avg_radius, member_total, cluster_total, pad
   output logic [1:0]  rsp_tuser    // created, dropped
);
   import occu_pkg::*;

   cmd_type     cmd;
   stat_type    stat;
   logic [3:0]  res_index;
   logic        res_created, res_dropped;
   logic [15:0] res_x, res_y, res_r, res_members;
   logic [4:0]  res_total;

   assign csr_ready = 1'b1;

   occu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   occu_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .in_first    (req_tuser),
      .in_x        (req_tdata[15:0]),
      .in_y        (req_tdata[31:16]),
      .in_r        (req_tdata[47:32]),
      .cmd         (cmd),
      .stat        (stat),
      .res_index   (res_index),
      .res_created (res_created),
      .res_dropped (res_dropped),
      .res_x       (res_x),
      .res_y       (res_y),
      .res_r       (res_r),
      .res_members (res_members),
      .res_total   (res_total)
   );

   assign rsp_tdata = {7'd0, res_total, res_members, res_r, res_y, res_x, res_index};
   assign rsp_tuser = {res_dropped, res_created};

endmodule
`default_nettype wire
